// File: src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types of the UTF-8 stream decoder
// One queue entry carries every result that a single input byte causes.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CpWidth    = 21;

  // Results of one input byte. Result k is raw_bytes[k] emitted as a single
  // byte, except that a completed sequence (dec set, cnt of one) emits the
  // decoded code point instead.
  typedef struct packed {
    logic [2:0]                       cnt;
    logic [MaxResults-1:0][7:0]       raw_bytes;
    logic                             dec;
    logic [CpWidth-1:0]               dec_cp;
    logic [2:0]                       dec_len;
    logic                             last_of_string;
  } entry_t;

endpackage

// File: src/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front: byte classifier and sequence tracker
// Holds a pending sequence and turns each byte with results into one entry.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            end_of_string,
  output logic            push_valid,
  input  logic            push_ready,
  output u8d_pkg::entry_t push_entry
);
  import u8d_pkg::*;

  localparam logic [7:0] AsciiTop  = 8'h80;
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] LeadE0Min = 8'hA0;
  localparam logic [7:0] LeadEdMax = 8'h9F;
  localparam logic [7:0] LeadEd    = 8'hED;
  localparam logic [7:0] LeadF0Min = 8'h90;
  localparam logic [7:0] LeadF4Max = 8'h8F;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    l = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) l = 3'd2;
    else if (b >= Lead3Lo && b <= Lead3Hi) l = 3'd3;
    else if (b >= Lead4Lo && b <= Lead4Hi) l = 3'd4;
    return l;
  endfunction

  logic [7:0] held [3];
  logic [1:0] held_count;
  logic [2:0] expected_len;

  logic [1:0] held_count_next;
  logic [2:0] expected_len_next;
  logic       hold_wr;
  logic [1:0] hold_pos;
  logic [2:0] n_res;
  logic       is_dec;
  logic       cont_ok;
  logic       complete;
  logic       fresh_emit;
  logic [2:0] fresh_len;
  logic [CpWidth-1:0] dec_cp;
  logic       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  assign fresh_len  = lead_len(data_byte);
  assign fresh_emit = (data_byte < AsciiTop) || (fresh_len == 3'd0) || end_of_string;
  assign complete   = ({1'b0, held_count} + 3'd1) == expected_len;

  always_comb begin
    cont_ok = (data_byte[7:6] == 2'b10);
    if (held_count == 2'd1) begin
      if (held[0] == Lead3Lo && data_byte < LeadE0Min) cont_ok = 1'b0;
      if (held[0] == LeadEd && data_byte > LeadEdMax) cont_ok = 1'b0;
      if (held[0] == Lead4Lo && data_byte < LeadF0Min) cont_ok = 1'b0;
      if (held[0] == Lead4Hi && data_byte > LeadF4Max) cont_ok = 1'b0;
    end
  end

  always_comb begin
    unique case (expected_len)
      3'd2:    dec_cp = {10'd0, held[0][4:0], data_byte[5:0]};
      3'd3:    dec_cp = {5'd0, held[0][3:0], held[1][5:0], data_byte[5:0]};
      default: dec_cp = {held[0][2:0], held[1][5:0], held[2][5:0], data_byte[5:0]};
    endcase
  end

  always_comb begin
    held_count_next   = held_count;
    expected_len_next = expected_len;
    hold_wr           = 1'b0;
    hold_pos          = 2'd0;
    n_res             = 3'd0;
    is_dec            = 1'b0;
    priority if (held_count == 2'd0) begin
      if (fresh_emit) begin
        n_res = 3'd1;
      end else begin
        hold_wr           = 1'b1;
        held_count_next   = 2'd1;
        expected_len_next = fresh_len;
      end
    end else if (cont_ok) begin
      if (complete) begin
        n_res             = 3'd1;
        is_dec            = 1'b1;
        held_count_next   = 2'd0;
        expected_len_next = 3'd0;
      end else if (end_of_string) begin
        n_res             = {1'b0, held_count} + 3'd1;
        held_count_next   = 2'd0;
        expected_len_next = 3'd0;
      end else begin
        hold_wr         = 1'b1;
        hold_pos        = held_count;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // Broken sequence: flush what is held, then treat the byte as new.
      if (fresh_emit) begin
        n_res             = {1'b0, held_count} + 3'd1;
        held_count_next   = 2'd0;
        expected_len_next = 3'd0;
      end else begin
        n_res             = {1'b0, held_count};
        hold_wr           = 1'b1;
        held_count_next   = 2'd1;
        expected_len_next = fresh_len;
      end
    end
  end

  always_comb begin
    push_entry.cnt            = n_res;
    push_entry.dec            = is_dec;
    push_entry.dec_cp         = dec_cp;
    push_entry.dec_len        = expected_len;
    push_entry.last_of_string = end_of_string;
    for (int i = 0; i < 3; i++) begin
      push_entry.raw_bytes[i] = (i < int'(held_count)) ? held[i] : data_byte;
    end
    push_entry.raw_bytes[3] = data_byte;
  end

  assign push_valid = accept && (n_res != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      expected_len <= 3'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      expected_len <= expected_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held[hold_pos] <= data_byte;
    end
  end

endmodule

// File: src/u8d_fifo.sv
// ----------------------------------------------------------------------------
// u8d_fifo: entry queue between classifier and emitter
// Four entries deep, so the classifier keeps taking bytes during flushes.
// ----------------------------------------------------------------------------
module u8d_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  u8d_pkg::entry_t push_entry,
  output logic            head_valid,
  input  logic            pop,
  output u8d_pkg::entry_t head_entry
);
  import u8d_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  entry_t          slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CntW'(Depth));
  assign head_valid = (fill != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PtrW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PtrW'(1);
      if (do_push && !do_pop) fill <= fill + CntW'(1);
      else if (do_pop && !do_push) fill <= fill - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: src/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back: result emitter
// Walks the head entry one result per cycle while the output is not
// stalled, numbers code points and tracks string validity.
// ----------------------------------------------------------------------------
module u8d_back #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  u8d_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [20:0]     code_point,
  output logic [2:0]      seq_bytes,
  output logic            malformed,
  output logic [31:0]     cp_index,
  output logic            run_last,
  output logic            string_end,
  output logic            string_valid
);
  import u8d_pkg::*;

  logic [1:0]            pos;
  logic [INDEX_BITS-1:0] cp_counter;
  logic                  seen_malformed;
  logic                  load;
  logic                  item_last;
  logic                  item_dec;
  logic                  item_mal;
  logic [7:0]            item_byte;
  logic                  item_eos;

  assign load      = head_valid && (!out_valid || out_ready);
  assign item_last = ({1'b0, pos} == (head_entry.cnt - 3'd1));
  assign item_byte = head_entry.raw_bytes[pos];
  assign item_dec  = head_entry.dec && item_last;
  assign item_mal  = !item_dec && item_byte[7];
  assign item_eos  = item_last && head_entry.last_of_string;
  assign pop       = load && item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      pos            <= 2'd0;
      cp_counter     <= '0;
      seen_malformed <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        pos <= item_last ? 2'd0 : pos + 2'd1;
        if (item_eos) begin
          cp_counter     <= '0;
          seen_malformed <= 1'b0;
        end else begin
          if (cp_counter != '1) cp_counter <= cp_counter + INDEX_BITS'(1);
          seen_malformed <= seen_malformed | item_mal;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point   <= item_dec ? head_entry.dec_cp : {13'd0, item_byte};
      seq_bytes    <= item_dec ? head_entry.dec_len : 3'd1;
      malformed    <= item_mal;
      cp_index     <= 32'(cp_counter);
      run_last     <= item_last;
      string_end   <= item_eos;
      string_valid <= item_eos && !(seen_malformed | item_mal);
    end
  end

endmodule

// File: src/utf8_lenient_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_lenient_stream_decoder: strict UTF-8 decoder for a byte stream
// Decodes code points, emits broken sequences as raw malformed bytes.
// ----------------------------------------------------------------------------
// Bytes arrive on the input channel with end_of_string marking the last byte
// of a string. Code points leave on the output channel with their running
// index (saturating at 2^INDEX_BITS-1, low 32 bits shown), the number of
// bytes they used, and run_last on the final result caused by a given input
// byte. A byte that only extends a pending sequence produces no result. A
// sequence that breaks, or that is cut short by the end of the string, is
// emitted byte by byte as raw, malformed results, after which the breaking
// byte is decoded afresh; one input byte can thus cause up to four results.
// The classifier front end accepts one byte per cycle while the queue has
// room and writes one queue entry per byte that produces results; the
// emitter back end sends one result per cycle while the output is not
// stalled. So the sustained rate is one byte per cycle when each byte causes
// at most one result and the output is not stalled, and a byte with n
// results holds the output until all n have gone out. The four-entry queue
// between the two lets the front keep accepting during such a flush until
// it fills; input ready drops only while it is full. The results of a byte
// are registered in a queue slot and then in the output register before
// they show on the output. On the final code point of a string, string_end
// is set and string_valid tells whether no byte of the string was malformed.
// ----------------------------------------------------------------------------
module utf8_lenient_stream_decoder #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic [2:0]  seq_bytes,
  output logic        malformed,
  output logic [31:0] cp_index,
  output logic        run_last,
  output logic        string_end,
  output logic        string_valid
);
  import u8d_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   head_valid;
  logic   pop;
  entry_t head_entry;

  // Front end: tracks the pending sequence and classifies each byte.
  u8d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // Queue of per-byte result groups.
  u8d_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_entry (head_entry)
  );

  // Back end: one result per cycle into the output register unless stalled.
  u8d_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point),
    .seq_bytes    (seq_bytes),
    .malformed    (malformed),
    .cp_index     (cp_index),
    .run_last     (run_last),
    .string_end   (string_end),
    .string_valid (string_valid)
  );

endmodule

// File: src/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker: port-level checks for the UTF-8 stream decoder
// Watches the output channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        end_of_string,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [2:0]  seq_bytes,
  input logic        malformed,
  input logic [31:0] cp_index,
  input logic        run_last,
  input logic        string_end,
  input logic        string_valid
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(cp_index))
    else $error("stalled result changed");

  // The end of a string always closes the results of its byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string_end without run_last");

  // Validity is only reported on the end of a string.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && string_valid |-> string_end && !malformed)
    else $error("string_valid outside string_end");

  // Malformed results are single raw bytes at or above 0x80.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> seq_bytes == 3'd1 && code_point[20:8] == '0 && code_point[7])
    else $error("malformed result is not a raw high byte");

  // A result that follows one ending a string starts again at index zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && string_end |=> !out_valid || cp_index == 32'd0)
    else $error("index not restarted after string end");

endmodule

bind utf8_lenient_stream_decoder u8d_checker u_checker (.*);
